// ===== hdl/wht_pkg.sv =====
package wht_pkg;

  localparam int MAX_LOG_LENGTH_DEF = 10;

  localparam int OP_W  = 2;
  localparam int IDX_W = 10;
  localparam int VAL_W = 30;
  localparam int CFG_W = 4;

  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 32;

  localparam logic [CFG_W-1:0] LOG_LENGTH_RST = 4'd10;
  localparam logic [VAL_W-1:0] MODULUS        = 30'd998244353;

  // cycles between the last butterfly of a stage and the first of the next
  localparam int DRAIN_CYCLES = 3;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic {
    KIND_DONE = 1'b0,
    KIND_READ = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic clr_we;
    logic wr_item;
    logic rd_item;
    logic bfly_issue;
    logic run_start;
    logic out_done;
    logic out_read;
  } dp_cmd_t;

endpackage

// ===== hdl/wht_ctrl.sv =====
module wht_ctrl
  import wht_pkg::*;
#(
  parameter int MAX_LOG_LENGTH = MAX_LOG_LENGTH_DEF,
  localparam int HW  = (MAX_LOG_LENGTH > 1) ? MAX_LOG_LENGTH - 1 : 1,
  localparam int LGW = $clog2(MAX_LOG_LENGTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  input  logic [OP_W-1:0]  in_op_i,
  output logic             in_ready_o,
  input  logic             out_ready_i,
  output dp_cmd_t          cmd_o,
  output logic [HW-1:0]    clr_addr_o,
  output logic [HW-1:0]    bfly_j_o,
  output logic [LGW-1:0]   bfly_s_o
);

  localparam int DW = $clog2(DRAIN_CYCLES);

  state_e state_q, state_d;

  logic [CFG_W-1:0] log_length_q;
  logic [LGW-1:0]   lg_eff;
  logic [LGW-1:0]   lg_q, lg_d;
  logic [LGW-1:0]   s_q, s_d;
  logic [LGW-1:0]   s_last;
  logic [HW-1:0]    j_q, j_d;
  logic [HW-1:0]    j_last;
  logic [HW-1:0]    clr_addr_q, clr_addr_d;
  logic [DW-1:0]    drain_q, drain_d;
  logic             drain_last;
  logic             in_fire;
  op_e              op;

  assign op         = op_e'(in_op_i);
  assign in_fire    = in_valid_i && (state_q == ST_IDLE);
  assign s_last     = lg_q - LGW'(1);
  assign j_last     = HW'((32'd1 << s_last) - 32'd1);
  assign drain_last = (drain_q == DW'(DRAIN_CYCLES - 1));

  always_comb begin
    if (int'(log_length_q) > MAX_LOG_LENGTH) begin
      lg_eff = LGW'(MAX_LOG_LENGTH);
    end else begin
      lg_eff = LGW'(log_length_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_length_q <= LOG_LENGTH_RST;
    end else if (cfg_we_i) begin
      log_length_q <= cfg_wdata_i;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_addr_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (op)
            OP_RUN:  state_d = (lg_eff == '0) ? ST_DONE : ST_RUN;
            OP_READ: state_d = ST_READ;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      ST_RUN: begin
        if (j_q == j_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (drain_last) state_d = (s_q == s_last) ? ST_DONE : ST_RUN;
      end
      ST_DONE: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: cmd_o.clr_we = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_fire) begin
          case (op)
            OP_WRITE: cmd_o.wr_item   = 1'b1;
            OP_RUN:   cmd_o.run_start = 1'b1;
            OP_READ:  cmd_o.rd_item   = 1'b1;
            default:  cmd_o           = '0;
          endcase
        end
      end
      ST_READ:  cmd_o.out_read   = out_ready_i;
      ST_RUN:   cmd_o.bfly_issue = 1'b1;
      ST_DONE:  cmd_o.out_done   = out_ready_i;
      default:  cmd_o            = '0;
    endcase
  end

  // counters
  always_comb begin
    clr_addr_d = clr_addr_q;
    lg_d       = lg_q;
    s_d        = s_q;
    j_d        = j_q;
    drain_d    = '0;
    case (state_q)
      ST_CLEAR: clr_addr_d = clr_addr_q + HW'(1);
      ST_IDLE: begin
        j_d = '0;
        s_d = '0;
        if (in_fire && (op == OP_RUN)) lg_d = lg_eff;
      end
      ST_RUN: begin
        j_d = (j_q == j_last) ? '0 : j_q + HW'(1);
      end
      ST_DRAIN: begin
        drain_d = drain_q + DW'(1);
        if (drain_last && (s_q != s_last)) s_d = s_q + LGW'(1);
      end
      default: drain_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
      lg_q       <= '0;
      s_q        <= '0;
      j_q        <= '0;
      drain_q    <= '0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      lg_q       <= lg_d;
      s_q        <= s_d;
      j_q        <= j_d;
      drain_q    <= drain_d;
    end
  end

  assign clr_addr_o = clr_addr_q;
  assign bfly_j_o   = j_q;
  assign bfly_s_o   = s_q;

endmodule

// ===== hdl/wht_dp.sv =====
module wht_dp
  import wht_pkg::*;
#(
  parameter int MAX_LOG_LENGTH = MAX_LOG_LENGTH_DEF,
  localparam int HW  = (MAX_LOG_LENGTH > 1) ? MAX_LOG_LENGTH - 1 : 1,
  localparam int LGW = $clog2(MAX_LOG_LENGTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  input  logic [HW-1:0]        clr_addr_i,
  input  logic [HW-1:0]        bfly_j_i,
  input  logic [LGW-1:0]       bfly_s_i,
  input  logic [IDX_W-1:0]     in_index_i,
  input  logic [VAL_W-1:0]     in_value_i,
  input  logic                 in_inverse_i,
  input  logic                 m_axis_tready,
  output logic                 m_axis_tvalid,
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  output logic                 m_axis_tuser,
  output logic                 out_ready_o
);

  localparam int W     = MAX_LOG_LENGTH;
  localparam int DEPTH = 1 << HW;

  function automatic logic [VAL_W-1:0] mod_half(input logic [VAL_W-1:0] x);
    logic [VAL_W:0] t;
    t = {1'b0, x} + {1'b0, MODULUS};
    if (x[0]) begin
      return t[VAL_W:1];
    end else begin
      return x >> 1;
    end
  endfunction

  // two banks split by index parity: both halves of a butterfly land in different banks
  logic [VAL_W-1:0] mem0_q [DEPTH];
  logic [VAL_W-1:0] mem1_q [DEPTH];

  logic [W-1:0]  idx_w, j_w, bit_s, low_mask, a_w, b_w;
  logic          idx_par, a_par;
  logic [HW-1:0] idx_baddr, a_baddr, b_baddr;

  logic          rd_en;
  logic [HW-1:0] rd0_addr, rd1_addr;
  logic [VAL_W-1:0] rd0_q, rd1_q;

  logic          we0, we1;
  logic [HW-1:0] wa0, wa1;
  logic [VAL_W-1:0] wd0, wd1, wr_val;

  logic          inv_q;
  logic          v1_q, v2_q, v3_q;
  logic          p1_q, p2_q, p3_q;
  logic [HW-1:0] a1_q, b1_q, a2_q, b2_q, a3_q, b3_q;
  logic [VAL_W-1:0] s2_q, d2_q, s3_q, d3_q;
  logic [VAL_W-1:0] u, v, s_mod, d_mod;
  logic [VAL_W:0]   sum, diff;

  logic             m_valid_q;
  kind_e            kind_q;
  logic [VAL_W-1:0] data_q;

  assign idx_w     = W'(in_index_i);
  assign idx_par   = ^idx_w;
  assign idx_baddr = HW'(idx_w >> 1);

  assign j_w      = W'(bfly_j_i);
  assign bit_s    = W'(1) << bfly_s_i;
  assign low_mask = bit_s - W'(1);
  assign a_w      = ((j_w & ~low_mask) << 1) | (j_w & low_mask);
  assign b_w      = a_w | bit_s;
  assign a_par    = ^a_w;
  assign a_baddr  = HW'(a_w >> 1);
  assign b_baddr  = HW'(b_w >> 1);

  assign rd_en = cmd_i.bfly_issue || cmd_i.rd_item;

  always_comb begin
    if (cmd_i.rd_item) begin
      rd0_addr = idx_baddr;
      rd1_addr = idx_baddr;
    end else begin
      rd0_addr = a_par ? b_baddr : a_baddr;
      rd1_addr = a_par ? a_baddr : b_baddr;
    end
  end

  assign wr_val = (in_value_i >= MODULUS) ? in_value_i - MODULUS : in_value_i;

  always_comb begin
    we0 = 1'b0;
    we1 = 1'b0;
    wa0 = a3_q;
    wa1 = b3_q;
    wd0 = s3_q;
    wd1 = d3_q;
    if (cmd_i.clr_we) begin
      we0 = 1'b1;
      we1 = 1'b1;
      wa0 = clr_addr_i;
      wa1 = clr_addr_i;
      wd0 = '0;
      wd1 = '0;
    end else if (cmd_i.wr_item) begin
      we0 = !idx_par;
      we1 = idx_par;
      wa0 = idx_baddr;
      wa1 = idx_baddr;
      wd0 = wr_val;
      wd1 = wr_val;
    end else if (v3_q) begin
      we0 = 1'b1;
      we1 = 1'b1;
      wa0 = p3_q ? b3_q : a3_q;
      wa1 = p3_q ? a3_q : b3_q;
      wd0 = p3_q ? d3_q : s3_q;
      wd1 = p3_q ? s3_q : d3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we0) mem0_q[wa0] <= wd0;
    if (we1) mem1_q[wa1] <= wd1;
    if (rd_en) begin
      rd0_q <= mem0_q[rd0_addr];
      rd1_q <= mem1_q[rd1_addr];
    end
  end

  // butterfly arithmetic
  assign u     = p1_q ? rd1_q : rd0_q;
  assign v     = p1_q ? rd0_q : rd1_q;
  assign sum   = {1'b0, u} + {1'b0, v};
  assign diff  = {1'b0, u} - {1'b0, v};
  assign s_mod = (sum >= {1'b0, MODULUS}) ? VAL_W'(sum - {1'b0, MODULUS}) : VAL_W'(sum);
  assign d_mod = diff[VAL_W] ? VAL_W'(diff + {1'b0, MODULUS}) : VAL_W'(diff);

  always_ff @(posedge clk_i) begin
    if (cmd_i.run_start) inv_q <= in_inverse_i;
    if (rd_en) begin
      p1_q <= cmd_i.rd_item ? idx_par : a_par;
      a1_q <= a_baddr;
      b1_q <= b_baddr;
    end
    p2_q <= p1_q;
    a2_q <= a1_q;
    b2_q <= b1_q;
    s2_q <= s_mod;
    d2_q <= d_mod;
    p3_q <= p2_q;
    a3_q <= a2_q;
    b3_q <= b2_q;
    s3_q <= inv_q ? mod_half(s2_q) : s2_q;
    d3_q <= inv_q ? mod_half(d2_q) : d2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.bfly_issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // result beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.out_read || cmd_i.out_done) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_read) begin
      kind_q <= KIND_READ;
      data_q <= u;
    end else if (cmd_i.out_done) begin
      kind_q <= KIND_DONE;
      data_q <= '0;
    end
  end

  assign out_ready_o   = !m_valid_q || m_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W - VAL_W){1'b0}}, data_q};
  assign m_axis_tuser  = kind_q;

  a_bfly_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (s3_q < MODULUS) && (d3_q < MODULUS))
    else $error("butterfly result not reduced");

  a_read_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_read |-> (u < MODULUS))
    else $error("stored element not reduced");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_read || cmd_i.out_done) |-> (!m_valid_q || m_axis_tready))
    else $error("result beat overwritten");

  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_item || cmd_i.clr_we) |-> !v3_q)
    else $error("element write during butterfly writeback");

endmodule

// ===== hdl/walsh_hadamard_transform_modp_top.sv =====
// XOR Walsh-Hadamard transform over residues mod 998244353 on a store of
// 2^MAX_LOG_LENGTH elements. After reset the store is swept to zero, one row of
// both banks a cycle, with s_axis_tready low. A write beat is stored in the
// cycle it is accepted; a read beat is read from its bank into a register, then
// its result beat is registered. A run over L = min(log_length, MAX_LOG_LENGTH)
// does one butterfly a cycle, set by the single write port of each of the two
// parity-split banks, plus a pipeline drain between stages. A run with L = 0
// just reports done. Inverse mode halves both butterfly outputs of every stage.
module walsh_hadamard_transform_modp_top
  import wht_pkg::*;
#(
  parameter int MAX_LOG_LENGTH = MAX_LOG_LENGTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // index, value, inverse
  input  logic [OP_W-1:0]      s_axis_tuser,  // op
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // data
  output logic                 m_axis_tuser   // kind
);

  localparam int HW  = (MAX_LOG_LENGTH > 1) ? MAX_LOG_LENGTH - 1 : 1;
  localparam int LGW = $clog2(MAX_LOG_LENGTH + 1);

  dp_cmd_t        cmd;
  logic [HW-1:0]  clr_addr;
  logic [HW-1:0]  bfly_j;
  logic [LGW-1:0] bfly_s;
  logic           out_ready;

  wht_ctrl #(
    .MAX_LOG_LENGTH(MAX_LOG_LENGTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (out_ready),
    .cmd_o       (cmd),
    .clr_addr_o  (clr_addr),
    .bfly_j_o    (bfly_j),
    .bfly_s_o    (bfly_s)
  );

  wht_dp #(
    .MAX_LOG_LENGTH(MAX_LOG_LENGTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .clr_addr_i    (clr_addr),
    .bfly_j_i      (bfly_j),
    .bfly_s_i      (bfly_s),
    .in_index_i    (s_axis_tdata[IDX_W-1:0]),
    .in_value_i    (s_axis_tdata[IDX_W+VAL_W-1:IDX_W]),
    .in_inverse_i  (s_axis_tdata[IDX_W+VAL_W]),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .out_ready_o   (out_ready)
  );

endmodule
